### hw/rtl/lpfc_pkg.sv
`default_nettype none

package lpfc_pkg;

   localparam int unsigned BYTE_W   = 8;
   localparam int unsigned LEN_W    = 32;
   localparam int unsigned STATUS_W = 3;
   localparam int unsigned COUNT_W  = 3;

   // Number of bytes in the length header and in the checksum trailer.
   localparam logic [COUNT_W-1:0] FIELD_BYTES = 3'd4;

   localparam logic [LEN_W-1:0] MAX_LENGTH_RESET = 32'd1048576;

   // Result status codes.
   localparam logic [STATUS_W-1:0] ST_HEADER  = 3'd0;
   localparam logic [STATUS_W-1:0] ST_PAYLOAD = 3'd1;
   localparam logic [STATUS_W-1:0] ST_CHECK   = 3'd2;
   localparam logic [STATUS_W-1:0] ST_GOOD    = 3'd3;
   localparam logic [STATUS_W-1:0] ST_BAD     = 3'd4;

   // A received byte held in the input register.
   typedef struct packed {
      logic              valid;
      logic [BYTE_W-1:0] data;
   } lpfc_beat_type;

   // One result beat.
   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [BYTE_W-1:0]   payload_byte;
      logic [LEN_W-1:0]    frame_length;
   } lpfc_result_type;

endpackage

`default_nettype wire

### hw/rtl/lpfc_input_stage.sv
`default_nettype none

module lpfc_input_stage (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [7:0]            req_tdata,
   input  wire logic                  advance,
   output lpfc_pkg::lpfc_beat_type    beat
);
   import lpfc_pkg::*;

   logic              valid_ff;
   logic              valid_in;
   logic [BYTE_W-1:0] data_ff;
   logic [BYTE_W-1:0] data_in;

   // The register can take a byte when it is empty or is being drained.
   assign req_tready = !valid_ff || advance;

   always_comb begin
      valid_in = req_tready ? req_tvalid : valid_ff;
      data_in  = (req_tready && req_tvalid) ? req_tdata : data_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign beat.valid = valid_ff;
   assign beat.data  = data_ff;

endmodule

`default_nettype wire

### hw/rtl/lpfc_core.sv
`default_nettype none

module lpfc_core #(
   parameter int unsigned CHECKSUM_BITS = 32
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    csr_write,
   input  wire logic [31:0]             csr_data,
   input  wire lpfc_pkg::lpfc_beat_type beat,
   output logic                         advance,
   output logic                         out_valid,
   input  wire logic                    out_ready,
   output lpfc_pkg::lpfc_result_type    result
);
   import lpfc_pkg::*;

   localparam int unsigned CMP_W = (CHECKSUM_BITS > LEN_W) ? CHECKSUM_BITS : LEN_W;

   logic [LEN_W-1:0]         max_length_ff, max_length_in;
   logic [LEN_W-1:0]         length_ff, length_in;
   logic [COUNT_W-1:0]       count_ff, count_in;
   logic [LEN_W-1:0]         position_ff, position_in;
   logic [CHECKSUM_BITS-1:0] sum_ff, sum_in;
   logic [LEN_W-1:0]         expected_ff, expected_in;
   logic                     out_valid_ff, out_valid_in;
   lpfc_result_type          result_ff, result_in;

   logic                     fire;
   logic [LEN_W+BYTE_W-1:0]  header_next;
   logic                     header_over;
   logic [CHECKSUM_BITS-1:0] sum_add;
   logic [LEN_W-1:0]         expected_next;
   logic [COUNT_W-1:0]       count_next;
   logic                     sum_match;
   logic                     in_header;
   logic                     payload_first;
   logic                     payload_more;
   logic                     in_trailer;

   assign advance   = !out_valid_ff || out_ready;
   assign fire      = advance && beat.valid;
   assign out_valid = out_valid_ff;
   assign result    = result_ff;

   always_comb begin
      header_next   = {length_ff, beat.data};
      header_over   = header_next > {{BYTE_W{1'b0}}, max_length_ff};
      sum_add       = sum_ff + CHECKSUM_BITS'(beat.data);
      expected_next = (count_ff < FIELD_BYTES) ? {expected_ff[LEN_W-BYTE_W-1:0], beat.data}
                                               : expected_ff;
      count_next    = (count_ff < FIELD_BYTES) ? count_ff + 3'd1 : count_ff;
      sum_match     = CMP_W'(expected_next) == CMP_W'(sum_ff);

      in_header     = (position_ff == '0) && (count_ff < FIELD_BYTES);
      payload_first = (length_ff != '0) && (position_ff == '0) && (count_ff == FIELD_BYTES);
      payload_more  = (position_ff != '0) && (position_ff < length_ff) && (count_ff == '0);
      in_trailer    = (position_ff != '0) && (position_ff == length_ff);
   end

   always_comb begin
      max_length_in = csr_write ? csr_data : max_length_ff;
      length_in     = length_ff;
      count_in      = count_ff;
      position_in   = position_ff;
      sum_in        = sum_ff;
      expected_in   = expected_ff;
      out_valid_in  = advance ? beat.valid : out_valid_ff;
      result_in     = result_ff;

      if (fire) begin
         // Anything not matched below is an error: the frame state clears.
         result_in.status       = ST_BAD;
         result_in.payload_byte = '0;
         result_in.frame_length = '0;
         length_in              = '0;
         count_in               = '0;
         position_in            = '0;
         sum_in                 = '0;
         expected_in            = '0;

         if (in_header) begin
            if (!header_over) begin
               length_in        = header_next[LEN_W-1:0];
               count_in         = count_ff + 3'd1;
               result_in.status = ST_HEADER;
            end
         end else if (payload_first) begin
            if (length_ff <= max_length_ff) begin
               position_in            = 32'd1;
               length_in              = length_ff;
               sum_in                 = sum_add;
               result_in.status       = ST_PAYLOAD;
               result_in.payload_byte = beat.data;
            end
         end else if (payload_more) begin
            length_in              = length_ff;
            position_in            = position_ff + 32'd1;
            sum_in                 = sum_add;
            result_in.status       = ST_PAYLOAD;
            result_in.payload_byte = beat.data;
         end else if (in_trailer) begin
            if (count_next < FIELD_BYTES) begin
               length_in        = length_ff;
               position_in      = position_ff;
               sum_in           = sum_ff;
               expected_in      = expected_next;
               count_in         = count_next;
               result_in.status = ST_CHECK;
            end else if (sum_match) begin
               result_in.status       = ST_GOOD;
               result_in.frame_length = length_ff;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_length_ff <= MAX_LENGTH_RESET;
         length_ff     <= '0;
         count_ff      <= '0;
         position_ff   <= '0;
         sum_ff        <= '0;
         expected_ff   <= '0;
         out_valid_ff  <= 1'b0;
      end else begin
         max_length_ff <= max_length_in;
         length_ff     <= length_in;
         count_ff      <= count_in;
         position_ff   <= position_in;
         sum_ff        <= sum_in;
         expected_ff   <= expected_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      result_ff <= result_in;
   end

endmodule

`default_nettype wire

### hw/rtl/length_prefixed_frame_checker.sv
// A byte accepted on req_ is held in the input register, then moves into the result
// register, from which its result beat is offered on rsp_ until rsp_tready takes it.
// Throughput: one byte per cycle, limited only by rsp_tready back-pressure.
// Reset is synchronous and active high; it clears the frame state, empties both
// registers and sets max_length to 1048576.
`default_nettype none

module length_prefixed_frame_checker #(
   parameter int unsigned CHECKSUM_BITS = 32
) (
   input  wire logic        clock,
   input  wire logic        reset,

   // Configuration: max_length, written whenever csr_valid is high.
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [31:0] csr_data,

   // Received byte stream.
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] data_byte

   // Result stream, one beat per received byte.
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [39:0]      rsp_tdata,   // [7:0] payload_byte, [39:8] frame_length
   output logic [2:0]       rsp_tuser    // [2:0] status
);
   import lpfc_pkg::*;

   lpfc_beat_type   beat;
   lpfc_result_type result;
   logic            advance;
   logic            csr_write;

   // The register file never stalls a write.
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   // The input register takes a new byte whenever it is empty or being drained, so
   // req_tready follows the result register only while the input register is full.
   lpfc_input_stage u_input (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .advance    (advance),
      .beat       (beat)
   );

   // The core parses the header, sums the payload, checks the trailer and
   // registers one result per byte.  The whole frame state updates in the
   // same cycle the byte moves into the result register.
   lpfc_core #(
      .CHECKSUM_BITS (CHECKSUM_BITS)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_data  (csr_data),
      .beat      (beat),
      .advance   (advance),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .result    (result)
   );

   assign rsp_tdata = {result.frame_length, result.payload_byte};
   assign rsp_tuser = result.status;

endmodule

`default_nettype wire

### hw/rtl/lpfc_checker.sv
`default_nettype none

module lpfc_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [39:0] rsp_tdata,
   input wire logic [2:0]  rsp_tuser
);
   import lpfc_pkg::*;

   // Only the five defined status codes may appear.
   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tuser <= ST_BAD))
      else $error("undefined status code on result");

   // The byte field is zero unless the beat carries payload.
   a_payload_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser != ST_PAYLOAD) |-> (rsp_tdata[7:0] == 8'd0))
      else $error("payload byte set on a non-payload beat");

   // The length field is zero except on a good verdict.
   a_length_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser != ST_GOOD) |-> (rsp_tdata[39:8] == 32'd0))
      else $error("frame length set on a beat that is not a good verdict");

   // A good frame always has a nonzero length.
   a_good_nonzero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser == ST_GOOD) |-> (rsp_tdata[39:8] != 32'd0))
      else $error("good verdict with zero frame length");

   // A stalled result beat holds.
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=>
         (rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser)))
      else $error("result beat changed while stalled");

endmodule

bind length_prefixed_frame_checker lpfc_checker u_lpfc_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

`default_nettype wire

### dv/frame_verdict_checker.sv
module frame_verdict_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [31:0] csr_data,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [7:0]  req_tdata,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [39:0] rsp_tdata,
   input  logic [2:0]  rsp_tuser,
   output int          error_count,
   output int          awaited_count,
   output logic        parser_idle,
   output int          good_frames,
   output int          rejected_beats,
   output int          passed_bytes
);
   timeunit 1ns;
   timeprecision 1ps;

   import lpfc_pkg::*;

   // Parser state, tracked beat by beat as bytes are accepted.
   logic [LEN_W-1:0]   length_limit;
   logic [LEN_W-1:0]   frame_len;
   logic [COUNT_W-1:0] field_cnt;
   logic [LEN_W-1:0]   payload_pos;
   logic [LEN_W-1:0]   payload_sum;
   logic [LEN_W-1:0]   trailer_sum;

   lpfc_result_type awaited_results[$];

   function automatic void restart_frame();
      frame_len   = '0;
      field_cnt   = '0;
      payload_pos = '0;
      payload_sum = '0;
      trailer_sum = '0;
   endfunction

   // Advances the parser by one received byte and returns the result beat it causes.
   function automatic lpfc_result_type parse_byte(input logic [BYTE_W-1:0] rx);
      lpfc_result_type         res;
      logic [LEN_W+BYTE_W-1:0] grown;
      res        = '0;
      res.status = ST_BAD;
      grown      = {frame_len, rx};
      if (payload_pos == 0 && field_cnt < FIELD_BYTES) begin
         // The header is compared against the limit before it is cut to 32 bits.
         if (grown > {{BYTE_W{1'b0}}, length_limit}) begin
            restart_frame();
         end else begin
            frame_len  = grown[LEN_W-1:0];
            field_cnt  = field_cnt + 1'b1;
            res.status = ST_HEADER;
         end
      end else if (frame_len != 0 && payload_pos == 0 && field_cnt == FIELD_BYTES) begin
         // The limit may have moved since the header; it is checked once more here.
         if (frame_len > length_limit) begin
            restart_frame();
         end else begin
            payload_pos      = 1;
            field_cnt        = '0;
            payload_sum      = payload_sum + rx;
            res.status       = ST_PAYLOAD;
            res.payload_byte = rx;
         end
      end else if (payload_pos != 0 && payload_pos < frame_len && field_cnt == 0) begin
         payload_pos      = payload_pos + 1;
         payload_sum      = payload_sum + rx;
         res.status       = ST_PAYLOAD;
         res.payload_byte = rx;
      end else if (payload_pos != 0 && payload_pos == frame_len) begin
         if (field_cnt < FIELD_BYTES) begin
            trailer_sum = {trailer_sum[LEN_W-BYTE_W-1:0], rx};
            field_cnt   = field_cnt + 1'b1;
         end
         if (field_cnt < FIELD_BYTES) begin
            res.status = ST_CHECK;
         end else begin
            if (trailer_sum == payload_sum) begin
               res.status       = ST_GOOD;
               res.frame_length = frame_len;
            end
            restart_frame();
         end
      end else begin
         // A zero length header, or any other state that should not occur.
         restart_frame();
      end
      return res;
   endfunction

   always @(posedge clock) begin : watch
      lpfc_result_type seen;
      lpfc_result_type want;
      if (reset) begin
         length_limit = MAX_LENGTH_RESET;
         restart_frame();
         awaited_results.delete();
      end else begin
         // Results are taken first so that a beat never matches a byte of the same edge.
         if (rsp_tvalid && rsp_tready) begin
            seen.status       = rsp_tuser;
            seen.payload_byte = rsp_tdata[7:0];
            seen.frame_length = rsp_tdata[39:8];
            if (awaited_results.size() == 0) begin
               $display("%0t: unexpected result beat, status %0d byte %02h length %0d",
                        $time, seen.status, seen.payload_byte, seen.frame_length);
               error_count++;
            end else begin
               want = awaited_results.pop_front();
               if (seen.status !== want.status || seen.payload_byte !== want.payload_byte ||
                   seen.frame_length !== want.frame_length) begin
                  $display({"%0t: mismatch, expected status %0d byte %02h length %0d,",
                            " got status %0d byte %02h length %0d"},
                           $time, want.status, want.payload_byte, want.frame_length,
                           seen.status, seen.payload_byte, seen.frame_length);
                  error_count++;
               end else if (want.status == ST_GOOD) begin
                  good_frames++;
               end else if (want.status == ST_BAD) begin
                  rejected_beats++;
               end else if (want.status == ST_PAYLOAD) begin
                  passed_bytes++;
               end
            end
         end
         if (csr_valid && csr_ready) begin
            length_limit = csr_data;
         end
         if (req_tvalid && req_tready) begin
            awaited_results.push_back(parse_byte(req_tdata));
         end
      end
      awaited_count = awaited_results.size();
      parser_idle   = (payload_pos == 0 && field_cnt == 0 && frame_len == 0);
   end

endmodule

### dv/length_prefixed_frame_checker_test.sv
module length_prefixed_frame_checker_test;
   timeunit 1ns;
   timeprecision 1ps;

   import lpfc_pkg::*;

   // Rough number of bytes pushed into the block before the run winds down.
   localparam int RUN_ITEMS    = 1550;
   // Generous ceiling: every byte waiting out the longest sender gap and the
   // longest receiver stall still ends far below this.
   localparam int CYCLE_LIMIT  = 1000000;
   // Quiet cycles after the last result.
   localparam int DRAIN_CYCLES = 8;
   // Oversized headers, cut frames and noise are only sent while the limit is at
   // most this, so that a flush never has to walk through a long accidental payload.
   localparam logic [31:0] RECOVERABLE_LIMIT = 32'd255;

   // How a frame is built by send_frame.
   typedef enum logic [1:0] {
      WHOLE_FRAME,
      WRONG_SUM,
      CUT_SHORT
   } frame_shape_type;

   logic        clock;
   logic        reset;
   logic        csr_valid;
   logic        csr_ready;
   logic [31:0] csr_data;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;    // [7:0] data_byte
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [39:0] rsp_tdata;    // [7:0] payload_byte, [39:8] frame_length
   logic [2:0]  rsp_tuser;    // [2:0] status

   int          error_count;
   int          awaited_count;
   logic        parser_idle;
   int          good_frames;
   int          rejected_beats;
   int          passed_bytes;

   // Percent chance of a gap before a byte and of a stall after a ready beat.
   int          gap_pct;
   int          stall_pct;
   int          byte_count;
   int          setting_count;
   int          cycle_count;
   logic [31:0] limit_now;

   length_prefixed_frame_checker u_top (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // The checker watches all three channels, predicts every result beat and
   // reports how many mismatches it found and how many beats it still awaits.
   frame_verdict_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_data       (csr_data),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tuser      (rsp_tuser),
      .error_count    (error_count),
      .awaited_count  (awaited_count),
      .parser_idle    (parser_idle),
      .good_frames    (good_frames),
      .rejected_beats (rejected_beats),
      .passed_bytes   (passed_bytes)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Watchdog. A hang anywhere, including a result that never shows up,
   // ends here.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("length_prefixed_frame_checker_test: done, errors");
         $finish;
      end
   end

   // Length of an idle stretch: none unless the pct roll hits, then mostly a
   // short one and now and then a long one.
   function automatic int idle_span(input int pct);
      if ($urandom_range(0, 99) >= pct) return 0;
      if ($urandom_range(0, 9) == 0) return $urandom_range(8, 40);
      return $urandom_range(1, 3);
   endfunction

   // The result side stalls on its own schedule, independent of the sender.
   initial begin : result_side
      int hold;
      rsp_tready = 1'b0;
      hold       = 0;
      forever begin
         @(negedge clock);
         if (hold > 0) begin
            rsp_tready <= 1'b0;
            hold--;
         end else begin
            rsp_tready <= 1'b1;
            hold = idle_span(stall_pct);
         end
      end
   end

   // Sends one byte. Called at a falling edge; returns at the falling edge
   // after the beat was taken, with tvalid still high so that a following
   // byte can go out back to back. Every caller either sends again or lowers
   // tvalid at that same falling edge.
   task automatic send_byte(input logic [7:0] value);
      int gap;
      gap = idle_span(gap_pct);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= value;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
      byte_count++;
   endtask

   // Big-endian word, used for both the length header and the checksum trailer.
   task automatic send_word(input logic [31:0] value);
      for (int i = 3; i >= 0; i--) begin
         send_byte(value[8*i +: 8]);
      end
   endtask

   // Stops sending and waits until every predicted result beat has arrived.
   // It always returns at a later falling edge than the one that lowered tvalid.
   task automatic settle();
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (awaited_count != 0) @(negedge clock);
   endtask

   // Writes max_length. Only done once the block has gone quiet.
   task automatic write_limit(input logic [31:0] value);
      settle();
      csr_valid <= 1'b1;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
      limit_now = value;
      setting_count++;
   endtask

   // Pushes zero bytes until the parser is back at the start of a header.
   // Zeros finish any payload and trailer, then zero-length headers reject.
   task automatic flush_parser();
      while (!parser_idle) send_byte(8'h00);
   endtask

   // One frame of the given shape, its payload all ones, all zeros or random bytes.
   task automatic send_frame(input logic [31:0] len, input frame_shape_type shape);
      logic [31:0] total;
      logic [7:0]  value;
      int          fill;
      int          count;
      total = '0;
      fill  = $urandom_range(0, 7);
      count = (shape == CUT_SHORT) ? int'($urandom_range(0, len - 1)) : int'(len);
      send_word(len);
      for (int i = 0; i < count; i++) begin
         if (fill == 0) value = 8'hFF;
         else if (fill == 1) value = 8'h00;
         else value = 8'($urandom_range(0, 255));
         total = total + value;
         send_byte(value);
      end
      if (shape != CUT_SHORT) begin
         if (shape == WRONG_SUM) total = total ^ (32'd1 << $urandom_range(0, 31));
         send_word(total);
      end
   endtask

   // Payload length for a random frame: short most of the time, now and then
   // longer, never above the limit in force.
   function automatic logic [31:0] pick_length();
      logic [31:0] span;
      span = (limit_now < 32'd40) ? limit_now : 32'd40;
      if ($urandom_range(0, 19) == 0) span = (limit_now < 32'd200) ? limit_now : 32'd200;
      return $urandom_range(1, span);
   endfunction

   initial begin : stimulus
      logic [31:0] total;
      logic [7:0]  value;
      logic [31:0] next_limit;
      int          roll;
      int          events;
      reset      = 1'b1;
      csr_valid  = 1'b0;
      csr_data   = '0;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      gap_pct    = 0;
      stall_pct  = 0;
      limit_now  = MAX_LENGTH_RESET;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part, first under the reset limit. A one-byte frame and a
      // two-byte frame of all-ones payload, a corrupted checksum, a header of
      // zero followed by a byte that gets dropped, and a header one above the
      // limit that is rejected on its last byte.
      send_word(32'd1);
      send_byte(8'hFF);
      send_word(32'h0000_00FF);
      send_word(32'd2);
      send_byte(8'hFF);
      send_byte(8'hFF);
      send_word(32'h0000_01FE);
      send_frame(32'd5, WRONG_SUM);
      send_word(32'd0);
      send_byte(8'hA5);
      send_word(MAX_LENGTH_RESET + 32'd1);

      // Widest limit, then the narrowest: a frame of exactly the limit, a
      // header just above it, and a first header byte already above it.
      write_limit(32'hFFFF_FFFF);
      send_frame(32'd4, WHOLE_FRAME);
      write_limit(32'd1);
      send_frame(32'd1, WHOLE_FRAME);
      send_word(32'd2);
      send_byte(8'h80);

      // The limit drops between the header and the first payload byte: that
      // byte is rejected and dropped.
      write_limit(32'd20);
      send_word(32'd10);
      write_limit(32'd5);
      send_byte(8'h3C);

      // The limit drops once the payload is under way: the frame still passes.
      write_limit(32'd20);
      total = '0;
      send_word(32'd10);
      for (int i = 0; i < 3; i++) begin
         value = 8'($urandom_range(0, 255));
         total = total + value;
         send_byte(value);
      end
      write_limit(32'd2);
      for (int i = 0; i < 7; i++) begin
         value = 8'($urandom_range(0, 255));
         total = total + value;
         send_byte(value);
      end
      send_word(total);
      send_frame(32'd2, WHOLE_FRAME);
      send_word(32'd3);

      // Random part. Each phase picks a limit and an idling pattern, then
      // sends mostly well-formed frames with random content. Corrupted
      // checksums and zero-length headers recover on their own; oversized
      // headers, cut frames and raw noise are only sent under a small limit
      // and are followed by a flush back to the header state.
      while (byte_count < RUN_ITEMS) begin
         roll = $urandom_range(0, 9);
         case (roll)
            0: begin
               next_limit = 32'd1;
            end
            1: begin
               next_limit = 32'hFFFF_FFFF;
            end
            2: begin
               next_limit = MAX_LENGTH_RESET;
            end
            3: begin
               next_limit = RECOVERABLE_LIMIT;
            end
            default: begin
               next_limit = $urandom_range(2, 64);
            end
         endcase
         write_limit(next_limit);
         roll = $urandom_range(0, 3);
         gap_pct   = (roll == 0) ? 0 : (roll == 1) ? 10 : (roll == 2) ? 30 : 60;
         roll = $urandom_range(0, 3);
         stall_pct = (roll == 0) ? 0 : (roll == 1) ? 10 : (roll == 2) ? 30 : 60;
         events = $urandom_range(5, 25);
         for (int e = 0; e < events && byte_count < RUN_ITEMS; e++) begin
            roll = $urandom_range(0, 99);
            if (roll < 70) begin
               send_frame(pick_length(), WHOLE_FRAME);
            end else if (roll < 80) begin
               send_frame(pick_length(), WRONG_SUM);
            end else if (roll < 85) begin
               send_word(32'd0);
               send_byte(8'($urandom_range(0, 255)));
            end else if (limit_now > RECOVERABLE_LIMIT) begin
               send_frame(pick_length(), WHOLE_FRAME);
            end else if (roll < 90) begin
               send_word(limit_now + 32'd1 + $urandom_range(0, 1000));
               flush_parser();
            end else if (roll < 95) begin
               send_frame(pick_length(), CUT_SHORT);
               flush_parser();
            end else begin
               repeat ($urandom_range(1, 12)) send_byte(8'($urandom_range(0, 255)));
               flush_parser();
            end
            // Now and then the sender holds off until every result is back.
            if ($urandom_range(0, 19) == 0) settle();
         end
      end

      settle();
      repeat (DRAIN_CYCLES) @(negedge clock);
      $display("Sent %0d bytes under %0d limit settings with random gaps and stalls.",
               byte_count, setting_count);
      $display("Seen %0d payload bytes, %0d good frames and %0d rejections.",
               passed_bytes, good_frames, rejected_beats);
      if (error_count == 0 && awaited_count == 0) begin
         $display("length_prefixed_frame_checker_test: done, clean");
      end else begin
         $display("length_prefixed_frame_checker_test: done, errors");
      end
      $finish;
   end

endmodule

### sim.f
hw/rtl/lpfc_pkg.sv
hw/rtl/lpfc_input_stage.sv
hw/rtl/lpfc_core.sv
hw/rtl/length_prefixed_frame_checker.sv
hw/rtl/lpfc_checker.sv
dv/frame_verdict_checker.sv
dv/length_prefixed_frame_checker_test.sv
